[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst_n is low.
`define LIFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define LIFE_ASSERT_IMP(label, ante, cons, msg) \
    `LIFE_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define LIFE_ASSERT_NXT(label, ante, cons, msg) \
    `LIFE_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/life_pkg.sv]
`default_nettype none

package life_pkg;

    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 16;
    localparam int MAX_RESULTS   = 16;

    localparam int ROW_SEL_W = 4;
    localparam int CELLS_W   = 16;
    localparam int GEN_W     = 16;

    localparam logic [GEN_W-1:0] LIMIT_RESET = 16'd100;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Per-row control handed from the sequencer to each cell.
    typedef struct packed {
        logic wr;
        logic step;
        logic shift;
    } cell_ctl_t;

    // Conway's rule for one cell; mid[1] is the cell itself.
    function automatic logic life_rule(input logic [2:0] up,
                                       input logic [2:0] mid,
                                       input logic [2:0] dn);
        logic [3:0] n;
        n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
          + 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
        return (n == 4'd3) || (mid[1] && (n == 4'd2));
    endfunction

endpackage

`default_nettype wire

[rtl/life_cell.sv]
`default_nettype none

module life_cell #(
    parameter int GRID_COLS = life_pkg::GRID_COLS_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire life_pkg::cell_ctl_t ctl,
    input  wire [GRID_COLS-1:0]     up_row,
    input  wire [GRID_COLS-1:0]     dn_row,
    input  wire [GRID_COLS-1:0]     load_row,
    output logic [GRID_COLS-1:0]    row,
    output logic                    live
);
    import life_pkg::*;

    logic [GRID_COLS-1:0] row_reg;
    logic [GRID_COLS-1:0] row_next;
    logic [GRID_COLS-1:0] gen_row;
    logic                 live_reg;

    for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
        localparam int L = (c == 0) ? GRID_COLS - 1 : c - 1;
        localparam int R = (c == GRID_COLS - 1) ? 0 : c + 1;
        assign gen_row[c] = life_rule({up_row[R], up_row[c], up_row[L]},
                                      {row_reg[R], row_reg[c], row_reg[L]},
                                      {dn_row[R], dn_row[c], dn_row[L]});
    end

    // The ring rotates towards row 0, so the shift source is the row below.
    always_comb
    begin
        row_next = row_reg;
        if (ctl.wr)
        begin
            row_next = load_row;
        end
        else if (ctl.step)
        begin
            row_next = gen_row;
        end
        else if (ctl.shift)
        begin
            row_next = dn_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            live_reg <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            live_reg <= |row_next;
        end
    end

    assign row  = row_reg;
    assign live = live_reg;

endmodule

`default_nettype wire

[rtl/life_automaton_toroidal_step.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// in       | in_valid / in_ready    | func, row_select, row_cells
// out      | out_valid / out_ready  | out_row, out_cells, last_row, advanced,
//          |                        | grid_empty, generation_count
// cfg      | cfg_wr_en              | cfg_wr_data (generation_limit)
//
// A load item writes its row cell as it is taken. An advancing step updates every
// row cell at once, then the row ring rotates past row 0, one emitted row per cycle
// while the output is not stalled, for the first EMIT_N rows; the rest rotate home.
// A refused step passes through S_REFUSE and gives a single result.
// Output stalls hold the rotation; the output register lets the last result wait
// while the next item is taken. Reset clears the grid and the count and sets the
// limit to its default.
`default_nettype none

module life_automaton_toroidal_step #(
    parameter int GRID_ROWS = life_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = life_pkg::GRID_COLS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_wr_en,
    input  wire [life_pkg::GEN_W-1:0]     cfg_wr_data,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           func,
    input  wire [life_pkg::ROW_SEL_W-1:0] row_select,
    input  wire [life_pkg::CELLS_W-1:0]   row_cells,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [life_pkg::ROW_SEL_W-1:0] out_row,
    output logic [life_pkg::CELLS_W-1:0]  out_cells,
    output logic                          last_row,
    output logic                          advanced,
    output logic                          grid_empty,
    output logic [life_pkg::GEN_W-1:0]    generation_count
);
    import life_pkg::*;

    localparam int EMIT_N = (GRID_ROWS < MAX_RESULTS) ? GRID_ROWS : MAX_RESULTS;
    localparam int ROT_W  = $clog2(GRID_ROWS);
    localparam int SEL_W  = 7;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_REFUSE  = 4'b0010,
        S_EMIT    = 4'b0100,
        S_RESTORE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [ROT_W-1:0]     rot_reg, rot_next;
    logic [GEN_W-1:0]     gen_reg, gen_next;
    logic [GEN_W-1:0]     limit_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [ROW_SEL_W-1:0] out_row_reg, out_row_next;
    logic [CELLS_W-1:0]   out_cells_reg, out_cells_next;
    logic                 last_row_reg, last_row_next;
    logic                 advanced_reg, advanced_next;
    logic                 grid_empty_reg, grid_empty_next;
    logic [GEN_W-1:0]     gen_out_reg, gen_out_next;
    logic                 out_load;

    logic [GRID_COLS-1:0] cell_rows [GRID_ROWS];
    logic [GRID_ROWS-1:0] row_live;
    cell_ctl_t            cell_ctl [GRID_ROWS];
    logic [GRID_COLS-1:0] load_row;
    logic [SEL_W-1:0]     sel_ext;

    logic accept;
    logic load_go;
    logic step_go;
    logic shift_go;
    logic grid_live;
    logic can_step;
    logic slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign grid_live = |row_live;
    assign can_step  = (gen_reg < limit_reg) && grid_live;
    assign slot_free = !out_valid_reg || out_ready;
    assign load_go   = accept && (func == FUNC_LOAD);
    assign step_go   = accept && (func == FUNC_STEP) && can_step;
    assign load_row  = GRID_COLS'(row_cells);
    assign sel_ext   = SEL_W'(row_select);

    for (genvar i = 0; i < GRID_ROWS; i++) begin : g_row
        localparam int UP = (i == 0) ? GRID_ROWS - 1 : i - 1;
        localparam int DN = (i == GRID_ROWS - 1) ? 0 : i + 1;

        assign cell_ctl[i].wr    = load_go && (sel_ext == SEL_W'(i));
        assign cell_ctl[i].step  = step_go;
        assign cell_ctl[i].shift = shift_go;

        life_cell #(
            .GRID_COLS (GRID_COLS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl[i]),
            .up_row   (cell_rows[UP]),
            .dn_row   (cell_rows[DN]),
            .load_row (load_row),
            .row      (cell_rows[i]),
            .live     (row_live[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        rot_next        = rot_reg;
        gen_next        = gen_reg;
        shift_go        = 1'b0;
        out_load        = 1'b0;
        out_row_next    = out_row_reg;
        out_cells_next  = out_cells_reg;
        last_row_next   = last_row_reg;
        advanced_next   = advanced_reg;
        grid_empty_next = grid_empty_reg;
        gen_out_next    = gen_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (func == FUNC_STEP))
                begin
                    if (can_step)
                    begin
                        gen_next   = gen_reg + 16'd1;
                        rot_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_REFUSE;
                    end
                end
            end
            S_REFUSE:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_row_next    = '0;
                    out_cells_next  = '0;
                    last_row_next   = 1'b1;
                    advanced_next   = 1'b0;
                    grid_empty_next = !grid_live;
                    gen_out_next    = gen_reg;
                    state_next      = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    shift_go        = 1'b1;
                    out_row_next    = ROW_SEL_W'(rot_reg);
                    out_cells_next  = CELLS_W'(cell_rows[0]);
                    last_row_next   = (rot_reg == ROT_W'(EMIT_N - 1));
                    advanced_next   = 1'b1;
                    grid_empty_next = !grid_live;
                    gen_out_next    = gen_reg;
                    if (rot_reg == ROT_W'(GRID_ROWS - 1))
                    begin
                        rot_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rot_next = rot_reg + ROT_W'(1);
                        if (rot_reg == ROT_W'(EMIT_N - 1))
                        begin
                            state_next = S_RESTORE;
                        end
                    end
                end
            end
            S_RESTORE:
            begin
                // Rows past the last emitted one rotate back to their home cells.
                shift_go = 1'b1;
                if (rot_reg == ROT_W'(GRID_ROWS - 1))
                begin
                    rot_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    rot_next = rot_reg + ROT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
                rot_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rot_reg       <= '0;
            gen_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rot_reg       <= rot_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg    <= out_row_next;
        out_cells_reg  <= out_cells_next;
        last_row_reg   <= last_row_next;
        advanced_reg   <= advanced_next;
        grid_empty_reg <= grid_empty_next;
        gen_out_reg    <= gen_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_row          = out_row_reg;
    assign out_cells        = out_cells_reg;
    assign last_row         = last_row_reg;
    assign advanced         = advanced_reg;
    assign grid_empty       = grid_empty_reg;
    assign generation_count = gen_out_reg;

`include "assert_macros.svh"

    `LIFE_ASSERT_IMP(a_ring_home, state_reg == S_IDLE, rot_reg == '0,
                     "ring not home when idle")
    `LIFE_ASSERT_NXT(a_step_count, step_go,
                     (state_reg == S_EMIT) && (gen_reg == 16'($past(gen_reg) + 16'd1)),
                     "step did not advance count")
    `LIFE_ASSERT_IMP(a_last_row, out_valid_reg && advanced_reg && last_row_reg,
                     out_row_reg == ROW_SEL_W'(EMIT_N - 1), "last row index wrong")
    `LIFE_ASSERT_IMP(a_refused, out_valid_reg && !advanced_reg,
                     last_row_reg && (out_cells_reg == '0) && (out_row_reg == '0),
                     "refused result malformed")

endmodule

`default_nettype wire

[tb/tb_life_automaton_toroidal_step.sv]
`timescale 1ns / 1ps

module tb_life_automaton_toroidal_step;

    localparam int GRID_ROWS     = life_pkg::GRID_ROWS_DEF;
    localparam int GRID_COLS     = life_pkg::GRID_COLS_DEF;
    localparam int OUT_ROWS      = (GRID_ROWS < life_pkg::MAX_RESULTS) ?
                                   GRID_ROWS : life_pkg::MAX_RESULTS;
    localparam int SETTLE_CYCLES = 2 * GRID_ROWS + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 66;

    typedef struct {
        logic [life_pkg::ROW_SEL_W-1:0] row_idx;
        logic [life_pkg::CELLS_W-1:0]   cells;
        logic                           last_flag;
        logic                           adv_flag;
        logic                           empty_flag;
        logic [life_pkg::GEN_W-1:0]     gen_count;
    } row_result_t;

    class life_grid_model;
        logic [life_pkg::CELLS_W-1:0] grid [GRID_ROWS];
        logic [life_pkg::GEN_W-1:0]   gens;
        logic [life_pkg::GEN_W-1:0]   limit;
        row_result_t                  pending_rows [$];
        int mismatches, loads, advances, refusals, rows_seen;

        function void clear();
            foreach (grid[r])
                grid[r] = '0;
            gens  = '0;
            limit = life_pkg::LIMIT_RESET;
            pending_rows.delete();
            mismatches = 0;
            loads      = 0;
            advances   = 0;
            refusals   = 0;
            rows_seen  = 0;
        endfunction

        function bit is_empty();
            foreach (grid[r])
                if (grid[r] != '0)
                    return 1'b0;
            return 1'b1;
        endfunction

        // Every cell looks at its eight neighbours, wrapping round both edges.
        function void advance();
            logic [life_pkg::CELLS_W-1:0] nxt [GRID_ROWS];
            int n;
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                nxt[r] = '0;
                for (int c = 0; c < GRID_COLS; c++)
                begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (dr != 0 || dc != 0)
                                n += grid[(r + dr + GRID_ROWS) % GRID_ROWS]
                                         [(c + dc + GRID_COLS) % GRID_COLS];
                    nxt[r][c] = (n == 3) || (grid[r][c] && n == 2);
                end
            end
            grid = nxt;
            gens = gens + 1'b1;
        endfunction

        function void accept_item(logic f, logic [life_pkg::ROW_SEL_W-1:0] sel,
                                  logic [life_pkg::CELLS_W-1:0] cells);
            row_result_t res;
            if (f == life_pkg::FUNC_LOAD)
            begin
                if (sel < GRID_ROWS)
                    grid[sel] = cells;
                loads++;
                return;
            end
            if (gens >= limit || is_empty())
            begin
                res = '{row_idx: '0, cells: '0, last_flag: 1'b1, adv_flag: 1'b0,
                        empty_flag: is_empty(), gen_count: gens};
                pending_rows.push_back(res);
                refusals++;
                return;
            end
            advance();
            advances++;
            for (int r = 0; r < OUT_ROWS; r++)
            begin
                res.row_idx    = r[life_pkg::ROW_SEL_W-1:0];
                res.cells      = grid[r];
                res.last_flag  = (r == OUT_ROWS - 1);
                res.adv_flag   = 1'b1;
                res.empty_flag = is_empty();
                res.gen_count  = gens;
                pending_rows.push_back(res);
            end
        endfunction

        function void compare_row(logic [life_pkg::ROW_SEL_W-1:0] got_row,
                                  logic [life_pkg::CELLS_W-1:0] got_cells,
                                  logic got_last, logic got_adv, logic got_empty,
                                  logic [life_pkg::GEN_W-1:0] got_gens);
            row_result_t want;
            if (pending_rows.size() == 0)
            begin
                $error("Result for row %0d arrived with nothing outstanding", got_row);
                mismatches++;
                return;
            end
            want = pending_rows.pop_front();
            rows_seen++;
            if (got_row !== want.row_idx)
            begin
                $error("out_row: expected %0d, got %0d", want.row_idx, got_row);
                mismatches++;
            end
            if (got_cells !== want.cells)
            begin
                $error("out_cells: expected %h, got %h", want.cells, got_cells);
                mismatches++;
            end
            if (got_last !== want.last_flag)
            begin
                $error("last_row: expected %b, got %b", want.last_flag, got_last);
                mismatches++;
            end
            if (got_adv !== want.adv_flag)
            begin
                $error("advanced: expected %b, got %b", want.adv_flag, got_adv);
                mismatches++;
            end
            if (got_empty !== want.empty_flag)
            begin
                $error("grid_empty: expected %b, got %b", want.empty_flag, got_empty);
                mismatches++;
            end
            if (got_gens !== want.gen_count)
            begin
                $error("generation_count: expected %0d, got %0d",
                       want.gen_count, got_gens);
                mismatches++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n       = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [life_pkg::GEN_W-1:0]     cfg_wr_data = '0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    logic                           func        = life_pkg::FUNC_LOAD;
    logic [life_pkg::ROW_SEL_W-1:0] row_select  = '0;
    logic [life_pkg::CELLS_W-1:0]   row_cells   = '0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    logic [life_pkg::ROW_SEL_W-1:0] out_row;
    logic [life_pkg::CELLS_W-1:0]   out_cells;
    logic                           last_row;
    logic                           advanced;
    logic                           grid_empty;
    logic [life_pkg::GEN_W-1:0]     generation_count;

    life_grid_model model;
    bit             tx_calm     = 1'b0;
    bit             rx_calm     = 1'b0;
    int             tx_items    = 0;
    int             phases_run  = 0;
    int unsigned    cycle_count = 0;

    life_automaton_toroidal_step #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .row_select      (row_select),
        .row_cells       (row_cells),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_row         (out_row),
        .out_cells       (out_cells),
        .last_row        (last_row),
        .advanced        (advanced),
        .grid_empty      (grid_empty),
        .generation_count(generation_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d rows outstanding",
                     cycle_count, model.pending_rows.size());
            $display("[life_automaton_toroidal_step] ERROR");
            $finish;
        end
    end

    // Valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input logic f, input logic [life_pkg::ROW_SEL_W-1:0] sel,
                             input logic [life_pkg::CELLS_W-1:0] cells);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        row_select <= sel;
        row_cells  <= cells;
        do
            @(posedge clk);
        while (!in_ready);
        model.accept_item(f, sel, cells);
        tx_items++;
    endtask

    task automatic load_row(input logic [life_pkg::ROW_SEL_W-1:0] sel,
                            input logic [life_pkg::CELLS_W-1:0] cells);
        send_item(life_pkg::FUNC_LOAD, sel, cells);
    endtask

    // The fields of a step item are ignored, so they carry random values.
    task automatic step_grid();
        send_item(life_pkg::FUNC_STEP, life_pkg::ROW_SEL_W'($urandom),
                  life_pkg::CELLS_W'($urandom));
    endtask

    // Loads give no result, so allow the block time to finish one after the last row.
    task automatic wait_idle();
        while (model.pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_sequence();
        int kind, n, base, shift;
        logic [life_pkg::CELLS_W-1:0] cells;
        logic [2*life_pkg::CELLS_W-1:0] wide;
        kind = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            tx_calm = !tx_calm;
        if (kind < 15)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // A glider at a random place, rotated across the column edge.
                base  = $urandom_range(0, GRID_ROWS - 1);
                shift = $urandom_range(0, GRID_COLS - 1);
                for (int k = 0; k < 3; k++)
                begin
                    cells = (k == 0) ? 16'h0002 : (k == 1) ? 16'h0004 : 16'h0007;
                    wide  = {16'h0000, cells} << shift;
                    load_row(life_pkg::ROW_SEL_W'(base + k), wide[15:0] | wide[31:16]);
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    cells = life_pkg::CELLS_W'($urandom);
                    if ($urandom_range(0, 2) != 0)
                        cells &= life_pkg::CELLS_W'($urandom);
                    if ($urandom_range(0, 2) == 0)
                        cells &= life_pkg::CELLS_W'($urandom);
                    load_row(life_pkg::ROW_SEL_W'($urandom_range(0, GRID_ROWS - 1)),
                             cells);
                end
            end
            n = $urandom_range(1, 8);
            repeat (n) step_grid();
        end
        else if (kind == 15)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
                load_row(life_pkg::ROW_SEL_W'(r), '0);
            step_grid();
        end
        else
        begin
            send_item(1'($urandom), life_pkg::ROW_SEL_W'($urandom),
                      life_pkg::CELLS_W'($urandom));
        end
    endtask

    task automatic run_phase(input logic [life_pkg::GEN_W-1:0] limit_value);
        int first_item;
        in_valid <= 1'b0;
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit_value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model.limit = limit_value;
        phases_run++;
        first_item = tx_items;
        while (tx_items - first_item < PHASE_ITEMS)
            random_sequence();
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            model.compare_row(out_row, out_cells, last_row, advanced, grid_empty,
                              generation_count);
        end
    end

    initial
    begin
        model = new();
        model.clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A step on the empty grid is refused, then a full row and wrapping shapes.
        send_item(life_pkg::FUNC_STEP, 4'hF, 16'hFFFF);
        load_row(4'h0, 16'hFFFF);
        send_item(life_pkg::FUNC_STEP, 4'h0, 16'h0000);
        step_grid();
        load_row(4'h4, 16'hAAAA);
        load_row(4'h5, 16'h5555);
        step_grid();
        load_row(4'h8, 16'h8003);
        load_row(4'hF, 16'hC000);
        load_row(4'h0, 16'hC000);
        step_grid();
        step_grid();
        step_grid();

        run_phase('0);
        run_phase(model.gens + 16'd6);
        run_phase(16'hFFFF);
        run_phase(life_pkg::GEN_W'($urandom));
        run_phase(model.gens + 16'd40);

        in_valid <= 1'b0;
        wait_idle();
        $display("Sent %0d items over %0d limit settings: %0d loads, %0d advancing steps,",
                 tx_items, phases_run, model.loads, model.advances);
        $display("%0d refused steps; compared %0d rows, generation count ended at %0d",
                 model.refusals, model.rows_seen, model.gens);
        if (model.mismatches == 0 && model.pending_rows.size() == 0)
            $display("[life_automaton_toroidal_step] OK");
        else
            $display("[life_automaton_toroidal_step] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/life_pkg.sv
rtl/life_cell.sv
rtl/life_automaton_toroidal_step.sv
tb/tb_life_automaton_toroidal_step.sv
